@@ src/c2u_pkg.sv @@
package c2u_pkg;

  // widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 16;
  localparam int unsigned IdxW  = 2;

  // code point ranges and case folding
  localparam logic [ByteW-1:0] HighHead    = 8'h80;
  localparam logic [CodeW-1:0] AsciiUpLo   = 16'h0041;
  localparam logic [CodeW-1:0] AsciiUpHi   = 16'h005A;
  localparam logic [CodeW-1:0] LatinUpLo   = 16'h00C0;
  localparam logic [CodeW-1:0] LatinUpHi   = 16'h00DE;
  localparam logic [CodeW-1:0] MulSign     = 16'h00D7;
  localparam logic [CodeW-1:0] CaseOffset  = 16'h0020;
  localparam logic [CodeW-1:0] OneByteLim  = 16'h0080;
  localparam logic [CodeW-1:0] TwoByteLim  = 16'h0800;

  // utf-8 byte prefixes
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [1:0] ContTag  = 2'b10;

  // index of the final byte of a sequence
  localparam logic [IdxW-1:0] LastIdx1 = 2'd0;
  localparam logic [IdxW-1:0] LastIdx2 = 2'd1;
  localparam logic [IdxW-1:0] LastIdx3 = 2'd2;

  // code point with its field mark
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             last_field;
  } c2u_cp_t;

  // encoded sequence of one to three bytes
  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [IdxW-1:0]  last_idx;
    logic             last_field;
  } c2u_enc_t;

  // cp1252 0x80-0x9f to code point
  function automatic logic [CodeW-1:0] c2u_high_map(input logic [4:0] idx);
    logic [CodeW-1:0] cp;
    case (idx)
      5'd0:  cp = 16'h20AC;
      5'd1:  cp = 16'h0081;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = 16'h008D;
      5'd14: cp = 16'h017D;
      5'd15: cp = 16'h008F;
      5'd16: cp = 16'h0090;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201C;
      5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd29: cp = 16'h009D;
      5'd30: cp = 16'h017E;
      default: cp = 16'h0178;
    endcase
    return cp;
  endfunction

endpackage

@@ src/c2u_decode.sv @@
module c2u_decode
  import c2u_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_field_i,
  output logic             stall_o,
  output logic             valid_o,
  output c2u_cp_t          data_o,
  input  logic             stall_i
);

  logic    valid_q;
  c2u_cp_t data_q, data_d;

  // table lookup for the cp1252 high block, identity elsewhere
  always_comb begin
    data_d.last_field = last_field_i;
    if (byte_i[7:5] == HighHead[7:5]) begin
      data_d.code = c2u_high_map(byte_i[4:0]);
    end else begin
      data_d.code = {{(CodeW-ByteW){1'b0}}, byte_i};
    end
  end

  assign stall_o = valid_q & stall_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/c2u_fold.sv @@
module c2u_fold
  import c2u_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  c2u_cp_t data_i,
  output logic    stall_o,
  output logic    valid_o,
  output c2u_cp_t data_o,
  input  logic    stall_i
);

  logic    valid_q;
  c2u_cp_t data_q, data_d;
  logic    is_upper;

  // ascii and latin-1 capitals, the multiplication sign excluded
  always_comb begin
    is_upper = ((data_i.code >= AsciiUpLo) && (data_i.code <= AsciiUpHi)) ||
               ((data_i.code >= LatinUpLo) && (data_i.code <= LatinUpHi) &&
                (data_i.code != MulSign));
    data_d.last_field = data_i.last_field;
    data_d.code       = is_upper ? (data_i.code + CaseOffset) : data_i.code;
  end

  assign stall_o = valid_q & stall_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/c2u_encode.sv @@
module c2u_encode
  import c2u_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  c2u_cp_t  data_i,
  output logic     stall_o,
  output logic     valid_o,
  output c2u_enc_t data_o,
  input  logic     stall_i
);

  logic     valid_q;
  c2u_enc_t data_q, data_d;

  // split the code point into one, two or three utf-8 bytes
  always_comb begin
    data_d.last_field = data_i.last_field;
    data_d.b1         = {ContTag, data_i.code[11:6]};
    data_d.b2         = {ContTag, data_i.code[5:0]};
    if (data_i.code < OneByteLim) begin
      data_d.b0       = data_i.code[ByteW-1:0];
      data_d.last_idx = LastIdx1;
    end else if (data_i.code < TwoByteLim) begin
      data_d.b0       = {Lead2Tag, data_i.code[10:6]};
      data_d.b1       = {ContTag, data_i.code[5:0]};
      data_d.last_idx = LastIdx2;
    end else begin
      data_d.b0       = {Lead3Tag, data_i.code[15:12]};
      data_d.last_idx = LastIdx3;
    end
  end

  assign stall_o = valid_q & stall_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/c2u_serial.sv @@
module c2u_serial
  import c2u_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  c2u_enc_t         data_i,
  output logic             stall_o,
  output logic             out_valid_o,
  output logic [ByteW-1:0] utf8_byte_o,
  output logic             last_of_char_o,
  output logic             last_of_field_o,
  input  logic             out_stall_i
);

  logic            valid_q;
  c2u_enc_t        data_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            is_last;
  logic            beat_done;
  logic            load;

  assign is_last   = (idx_q == data_q.last_idx);
  assign beat_done = valid_q & ~out_stall_i;
  // take a new sequence when empty or when its final beat leaves
  assign load      = ~valid_q | (beat_done & is_last);
  assign stall_o   = ~load;

  // byte index within the sequence
  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = '0;
    end else if (beat_done) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      data_q <= data_i;
    end
  end

  // output byte select
  always_comb begin
    case (idx_q)
      LastIdx1: utf8_byte_o = data_q.b0;
      LastIdx2: utf8_byte_o = data_q.b1;
      default:  utf8_byte_o = data_q.b2;
    endcase
  end

  assign out_valid_o     = valid_q;
  assign last_of_char_o  = is_last;
  assign last_of_field_o = is_last & data_q.last_field;

endmodule

@@ src/cp1252_to_utf8_lowercase.sv @@
// CP1252 to lowercase UTF-8 transcoder. One CP1252 byte enters per beat and
// leaves as one to three UTF-8 bytes, one per output beat, with the final
// byte marked last_of_char and, for a field-ending input, last_of_field.
// The path is a table lookup stage, a case fold stage and an encode stage,
// followed by the output register that serializes the bytes. The input side
// takes an item every cycle while no stage stalls; sustained throughput is
// set by the output serializer, which holds each item until its final byte
// has left, so two-byte and three-byte characters take longer than ASCII.
// No state is kept between items.
module cp1252_to_utf8_lowercase
  import c2u_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             last_in_field_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] utf8_byte_o,
  output logic             last_of_char_o,
  output logic             last_of_field_o
);

  logic     dec_valid, fold_valid, enc_valid;
  logic     dec_stall, fold_stall, enc_stall;
  c2u_cp_t  dec_data, fold_data;
  c2u_enc_t enc_data;

  // code point lookup
  c2u_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .byte_i       (byte_in_i),
    .last_field_i (last_in_field_i),
    .stall_o      (in_stall_o),
    .valid_o      (dec_valid),
    .data_o       (dec_data),
    .stall_i      (dec_stall)
  );

  // lowercase
  c2u_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .data_i  (dec_data),
    .stall_o (dec_stall),
    .valid_o (fold_valid),
    .data_o  (fold_data),
    .stall_i (fold_stall)
  );

  // utf-8 encode
  c2u_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fold_valid),
    .data_i  (fold_data),
    .stall_o (fold_stall),
    .valid_o (enc_valid),
    .data_o  (enc_data),
    .stall_i (enc_stall)
  );

  // byte serializer and output register
  c2u_serial u_serial (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (enc_valid),
    .data_i          (enc_data),
    .stall_o         (enc_stall),
    .out_valid_o     (out_valid_o),
    .utf8_byte_o     (utf8_byte_o),
    .last_of_char_o  (last_of_char_o),
    .last_of_field_o (last_of_field_o),
    .out_stall_i     (out_stall_i)
  );

endmodule

@@ src/c2u_checker.sv @@
module c2u_checker
  import c2u_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_stall_i,
  input logic [ByteW-1:0] utf8_byte_i,
  input logic             last_of_char_i,
  input logic             last_of_field_i
);

  // field mark only on the final byte of a character
  a_field_on_char_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && last_of_field_i) |-> last_of_char_i)
    else $error("last_of_field without last_of_char");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=>
      (out_valid_i && $stable(utf8_byte_i) && $stable(last_of_char_i) &&
       $stable(last_of_field_i)))
    else $error("stalled output beat changed");

  // a byte that does not end its character is followed by a continuation byte
  a_cont_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_stall_i && !last_of_char_i) |=>
      (out_valid_i && utf8_byte_i[7:6] == ContTag))
    else $error("missing utf-8 continuation byte");

  // uppercase ascii never leaves the block
  a_no_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(utf8_byte_i >= AsciiUpLo[ByteW-1:0] &&
                      utf8_byte_i <= AsciiUpHi[ByteW-1:0]))
    else $error("uppercase ascii on output");

endmodule

bind cp1252_to_utf8_lowercase c2u_checker u_c2u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .utf8_byte_i     (utf8_byte_o),
  .last_of_char_i  (last_of_char_o),
  .last_of_field_i (last_of_field_o)
);

@@ dv/cp1252_to_utf8_lowercase_scoreboard.sv @@
`timescale 1ns / 100ps

module cp1252_to_utf8_lowercase_scoreboard
  import c2u_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             last_in_field_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ByteW-1:0] utf8_byte_i,
  input  logic             last_of_char_i,
  input  logic             last_of_field_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      bytes_pending_o
);

  // one output beat of the utf-8 stream
  typedef struct packed {
    logic [7:0] data;
    logic       char_end;
    logic       field_end;
  } utf8_beat_t;

  utf8_beat_t utf8_expected[$];
  int unsigned mismatches = 0;

  // cp1252 0x80-0x9f to unicode, undefined slots stay c1 controls
  function automatic logic [15:0] win_high_code(input logic [4:0] slot);
    logic [15:0] code;
    case (slot)
      5'h00: code = 16'h20AC;
      5'h02: code = 16'h201A;
      5'h03: code = 16'h0192;
      5'h04: code = 16'h201E;
      5'h05: code = 16'h2026;
      5'h06: code = 16'h2020;
      5'h07: code = 16'h2021;
      5'h08: code = 16'h02C6;
      5'h09: code = 16'h2030;
      5'h0A: code = 16'h0160;
      5'h0B: code = 16'h2039;
      5'h0C: code = 16'h0152;
      5'h0E: code = 16'h017D;
      5'h11: code = 16'h2018;
      5'h12: code = 16'h2019;
      5'h13: code = 16'h201C;
      5'h14: code = 16'h201D;
      5'h15: code = 16'h2022;
      5'h16: code = 16'h2013;
      5'h17: code = 16'h2014;
      5'h18: code = 16'h02DC;
      5'h19: code = 16'h2122;
      5'h1A: code = 16'h0161;
      5'h1B: code = 16'h203A;
      5'h1C: code = 16'h0153;
      5'h1E: code = 16'h017E;
      5'h1F: code = 16'h0178;
      default: code = {11'h004, slot};
    endcase
    return code;
  endfunction

  // append one beat to the expected stream
  task automatic queue_beat(input utf8_beat_t beat);
    utf8_expected.insert(utf8_expected.size(), beat);
  endtask

  // map the byte, lowercase it and queue its utf-8 bytes
  task automatic predict_utf8(input logic [7:0] win_byte, input logic field_end);
    logic [15:0] code;
    if (win_byte[7:5] == 3'b100) code = win_high_code(win_byte[4:0]);
    else code = {8'h00, win_byte};
    if ((code >= 16'h0041 && code <= 16'h005A) ||
        (code >= 16'h00C0 && code <= 16'h00DE && code != 16'h00D7)) begin
      code = code + 16'h0020;
    end
    if (code < 16'h0080) begin
      queue_beat({code[7:0], 1'b1, field_end});
    end else if (code < 16'h0800) begin
      queue_beat({3'b110, code[10:6], 1'b0, 1'b0});
      queue_beat({2'b10, code[5:0], 1'b1, field_end});
    end else begin
      queue_beat({4'b1110, code[15:12], 1'b0, 1'b0});
      queue_beat({2'b10, code[11:6], 1'b0, 1'b0});
      queue_beat({2'b10, code[5:0], 1'b1, field_end});
    end
  endtask

  // compare output beats, then predict from input beats
  always @(posedge clk_i) begin : watch_beats
    utf8_beat_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (utf8_expected.size() == 0) begin
          $display("%0t: unexpected output beat: byte %h char_end %b field_end %b",
                   $time, utf8_byte_i, last_of_char_i, last_of_field_i);
          mismatches++;
        end else begin
          want = utf8_expected.pop_front();
          if (utf8_byte_i !== want.data) begin
            $display("%0t: utf8_byte expected %h actual %h", $time, want.data, utf8_byte_i);
            mismatches++;
          end
          if (last_of_char_i !== want.char_end) begin
            $display("%0t: last_of_char expected %b actual %b",
                     $time, want.char_end, last_of_char_i);
            mismatches++;
          end
          if (last_of_field_i !== want.field_end) begin
            $display("%0t: last_of_field expected %b actual %b",
                     $time, want.field_end, last_of_field_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_utf8(byte_in_i, last_in_field_i);
    end
    mismatch_count_o <= mismatches;
    bytes_pending_o  <= utf8_expected.size();
  end

endmodule

@@ dv/cp1252_to_utf8_lowercase_test.sv @@
`timescale 1ns / 100ps

module cp1252_to_utf8_lowercase_test;
  import c2u_pkg::*;

  localparam int unsigned HoldCycles = 150;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned RandItems  = 106;

  // field extremes, case edges and every class of the 0x80-0x9f block
  localparam logic [23:0][7:0] EdgeBytes = {
    8'h00, 8'h7F, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h61, 8'h7A,
    8'h80, 8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D, 8'h99, 8'h8A,
    8'h9F, 8'hA0, 8'hBF, 8'hC0, 8'hD7, 8'hDE, 8'hDF, 8'hFF
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] byte_in_i = '0;
  logic             last_in_field_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ByteW-1:0] utf8_byte_o;
  logic             last_of_char_o;
  logic             last_of_field_o;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned mismatch_count;
  int unsigned bytes_pending;
  int unsigned quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  cp1252_to_utf8_lowercase i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .byte_in_i,
    .last_in_field_i,
    .out_valid_o,
    .out_stall_i,
    .utf8_byte_o,
    .last_of_char_o,
    .last_of_field_o
  );

  cp1252_to_utf8_lowercase_scoreboard i_scoreboard (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i      (in_stall_o),
    .byte_in_i,
    .last_in_field_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .utf8_byte_i     (utf8_byte_o),
    .last_of_char_i  (last_of_char_o),
    .last_of_field_i (last_of_field_o),
    .mismatch_count_o(mismatch_count),
    .bytes_pending_o (bytes_pending)
  );

  // offer one input beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] win_byte, input logic field_end);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    byte_in_i       <= win_byte;
    last_in_field_i <= field_end;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering until every predicted byte has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (bytes_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // pick a byte biased toward the mapped block and the case-folded ranges
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(2))
      0: b = 8'h80 + 8'($urandom_range(31));
      1: b = $urandom_range(1) ? 8'h41 + 8'($urandom_range(25))
                               : 8'hC0 + 8'($urandom_range(31));
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // output side: random stalls, one long hold-off, calm stretch
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= !calm && ($urandom_range(99) < 8);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("cp1252_to_utf8_lowercase regression: fail");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned sent;
    int unsigned word_len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats, field mark on every third
    for (int i = 0; i < 24; i++) begin
      send_byte(EdgeBytes[i], (i % 3) == 2);
    end
    wait_drained();

    // random words, the last byte of each marks the field end
    hold_req <= 1'b1;
    sent = 0;
    while (sent < RandItems) begin
      word_len = $urandom_range(8, 1);
      for (int k = 0; k < word_len; k++) begin
        calm <= (sent >= 50 && sent < 90);
        send_byte(pick_byte(), k == word_len - 1);
        sent++;
      end
    end
    calm <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0 && bytes_pending == 0) begin
      $display("cp1252_to_utf8_lowercase regression: pass");
    end else begin
      $display("cp1252_to_utf8_lowercase regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/c2u_pkg.sv
src/c2u_decode.sv
src/c2u_fold.sv
src/c2u_encode.sv
src/c2u_serial.sv
src/cp1252_to_utf8_lowercase.sv
src/c2u_checker.sv
dv/cp1252_to_utf8_lowercase_scoreboard.sv
dv/cp1252_to_utf8_lowercase_test.sv
